@@ design/bitmap_slot_allocator_defines.svh @@
// Assertion macros shared by the bitmap slot allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define BSA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BSA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ design/bsa_pkg.sv @@
// Shared types and constants for the bitmap slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

   // Capacity and derived widths
   localparam int SLOTS   = 256;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = SLOT_W + 1;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_CLAIM = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_SAME  = 2'd3
   } status_type;

   // Outcome of a lowest-set-bit search
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } find_type;

endpackage

@@ design/bsa_find_first.sv @@
// Lowest-set-bit search over the slot bitmap, as a binary reduction tree.
`timescale 1ns / 1ps

module bsa_find_first (
   input  logic [bsa_pkg::SLOTS-1:0] bits,
   output bsa_pkg::find_type         result
);
   import bsa_pkg::*;

   // Reduce pairs level by level, keeping the left (lower) hit
   always_comb begin
      logic              hit [SLOTS];
      logic [SLOT_W-1:0] pos [SLOTS];
      for (int i = 0; i < SLOTS; i++) begin
         hit[i] = bits[i];
         pos[i] = SLOT_W'(i);
      end
      for (int lvl = 0; lvl < SLOT_W; lvl++) begin
         for (int n = 0; n < (SLOTS >> (lvl + 1)); n++) begin
            pos[n] = hit[2*n] ? pos[2*n] : pos[2*n+1];
            hit[n] = hit[2*n] | hit[2*n+1];
         end
      end
      result.found = hit[0];
      result.index = hit[0] ? pos[0] : '0;
   end

endmodule

@@ design/bitmap_slot_allocator.sv @@
// Top level of the bitmap slot allocator: request pipeline, free map and result register.
//
// Usage:
//   req_*  : request channel (valid/ready). req_kind selects allocate, free,
//            claim or query; req_slot_index names the slot for the last three.
//   rsp_*  : result channel (valid/ready), one result per request, in order.
//   csr_*  : write channel for slot_count, the number of usable slots.
//            Write it only while no request is in flight; csr_ready is high.
// Path: an accepted request loads the input register, then the map update stage
//   register, then the result register, which drives rsp_valid.
// Throughput: one request per cycle unless rsp_ready stalls the result channel.
//   The map update and the lowest-free search are combinational, so the next
//   request sees the updated map.
// Reset: every slot free, allocated count zero, slot_count 256, no result.
// Stall: while rsp_ready is low the result is held; the stages behind it fill
//   and req_ready drops once all three registers are occupied.
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bsa_pkg::kind_type             req_kind,
   input  logic [bsa_pkg::SLOT_W-1:0]    req_slot_index,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsa_pkg::SLOT_W-1:0]    rsp_slot,
   output bsa_pkg::status_type           rsp_status,
   output logic                          rsp_was_allocated,
   output logic [bsa_pkg::COUNT_W-1:0]   rsp_allocated_count,
   output logic [bsa_pkg::SLOT_W-1:0]    rsp_first_free,
   output logic                          rsp_any_free,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsa_pkg::COUNT_W-1:0]   csr_slot_count
);
   import bsa_pkg::*;

   // State
   logic [SLOTS-1:0]   free_map_ff, free_map_in;
   logic [COUNT_W-1:0] taken_count_ff, taken_count_in;
   logic [COUNT_W-1:0] slot_count_ff;

   // Input register
   logic               req_valid_ff;
   kind_type           req_kind_ff;
   logic [SLOT_W-1:0]  req_idx_ff;

   // Update stage register
   logic               mid_valid_ff;
   logic [SLOT_W-1:0]  mid_slot_ff, mid_slot_in;
   status_type         mid_status_ff, mid_status_in;
   logic               mid_was_ff, mid_was_in;

   // Result register
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   status_type         rsp_status_ff;
   logic               rsp_was_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [SLOT_W-1:0]  rsp_first_ff;
   logic               rsp_any_ff;

   logic               rsp_load, mid_load, mid_room, rsp_room, req_load;
   logic [SLOTS-1:0]   usable_mask;
   logic               in_range, slot_free;
   find_type           alloc_find, after_find;

   // Flow control: each register advances when the one ahead has room
   assign rsp_room  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = mid_valid_ff && rsp_room;
   assign mid_room  = !mid_valid_ff || rsp_room;
   assign mid_load  = req_valid_ff && mid_room;
   assign req_ready = !req_valid_ff || mid_room;
   assign req_load  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Usable slots lie below slot_count
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         usable_mask[i] = COUNT_W'(i) < slot_count_ff;
      end
   end

   bsa_find_first u_alloc_find (
      .bits   (free_map_ff & usable_mask),
      .result (alloc_find)
   );

   assign in_range  = {1'b0, req_idx_ff} < slot_count_ff;
   assign slot_free = free_map_ff[req_idx_ff];

   // Decode the request and work out the map and count after it
   always_comb begin
      free_map_in    = free_map_ff;
      taken_count_in = taken_count_ff;
      mid_slot_in    = req_idx_ff;
      mid_status_in  = STATUS_OK;
      mid_was_in     = 1'b0;
      if (req_kind_ff == KIND_ALLOC) begin
         if (alloc_find.found) begin
            mid_slot_in                   = alloc_find.index;
            free_map_in[alloc_find.index] = 1'b0;
            taken_count_in                = taken_count_ff + COUNT_W'(1);
         end else begin
            mid_slot_in   = '0;
            mid_status_in = STATUS_FULL;
         end
      end else if (!in_range) begin
         mid_status_in = STATUS_RANGE;
      end else begin
         mid_was_in = !slot_free;
         unique case (req_kind_ff)
            KIND_FREE: begin
               if (slot_free) begin
                  mid_status_in = STATUS_SAME;
               end else begin
                  free_map_in[req_idx_ff] = 1'b1;
                  taken_count_in          = taken_count_ff - COUNT_W'(1);
               end
            end
            KIND_CLAIM: begin
               if (!slot_free) begin
                  mid_status_in = STATUS_SAME;
               end else begin
                  free_map_in[req_idx_ff] = 1'b0;
                  taken_count_in          = taken_count_ff + COUNT_W'(1);
               end
            end
            default: begin
               // query and allocate leave the map alone here
            end
         endcase
      end
   end

   // Search the map as it stands after the transaction now in the update stage
   bsa_find_first u_after_find (
      .bits   (free_map_ff & usable_mask),
      .result (after_find)
   );

   // Control state and allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff    <= '1;
         taken_count_ff <= '0;
         slot_count_ff  <= COUNT_W'(SLOTS);
         req_valid_ff   <= 1'b0;
         mid_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            slot_count_ff <= csr_slot_count;
         end
         if (mid_load) begin
            free_map_ff    <= free_map_in;
            taken_count_ff <= taken_count_in;
         end
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (mid_room) begin
            mid_valid_ff <= req_valid_ff;
         end
         if (rsp_room) begin
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_load) begin
         req_kind_ff <= req_kind;
         req_idx_ff  <= req_slot_index;
      end
      if (mid_load) begin
         mid_slot_ff   <= mid_slot_in;
         mid_status_ff <= mid_status_in;
         mid_was_ff    <= mid_was_in;
      end
      if (rsp_load) begin
         rsp_slot_ff   <= mid_slot_ff;
         rsp_status_ff <= mid_status_ff;
         rsp_was_ff    <= mid_was_ff;
         rsp_count_ff  <= taken_count_ff;
         rsp_first_ff  <= after_find.index;
         rsp_any_ff    <= after_find.found;
      end
   end

   // Drive the result channel
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_was_allocated   = rsp_was_ff;
   assign rsp_allocated_count = rsp_count_ff;
   assign rsp_first_free      = rsp_first_ff;
   assign rsp_any_free        = rsp_any_ff;

   // Checks
   `BSA_ASSERT_ALWAYS(a_count_matches_map, clock, reset,
      ($countones(free_map_ff) + int'(taken_count_ff)) == SLOTS,
      "taken count disagrees with free map")
   `BSA_ASSERT_ALWAYS(a_count_bounded, clock, reset, taken_count_ff <= COUNT_W'(SLOTS),
      "taken count above capacity")
   `BSA_ASSERT_IMPLY(a_full_means_none_free, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_FULL), !rsp_any_ff,
      "full result reports a free slot")

endmodule
